// ===== rtl/array_priority_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the array priority queue
// Clocked, reset-qualified property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef ARRAY_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define ARRAY_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define APQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/apq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_pkg
// Shared sizes, codes and types of the array priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int CAPACITY  = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int VAL_W     = 16;
  localparam int PRI_W     = 8;
  localparam int CMD_W     = 2;
  localparam int STS_W     = 2;
  localparam int CNT_OUT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_CLEAR   = 2'd2
  } apq_cmd_e;

  typedef enum logic [STS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } apq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } apq_state_e;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] pri;
  } apq_entry_t;

  typedef struct packed {
    logic                 valid;
    logic [VAL_W-1:0]     value;
    apq_status_e          status;
    logic [CNT_OUT_W-1:0] count;
    logic                 is_empty;
    logic                 is_full;
  } apq_res_t;

  typedef struct packed {
    logic idle;
    logic cnt_zero;
  } apq_stat_t;

endpackage

// ===== rtl/apq_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module apq_store (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [apq_pkg::IDX_W-1:0] waddr_i,
  input  apq_pkg::apq_entry_t       wdata_i,
  input  logic [apq_pkg::IDX_W-1:0] raddr_i,
  output apq_pkg::apq_entry_t       rdata_o
);
  import apq_pkg::*;

  apq_entry_t mem [CAPACITY];
  apq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/apq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_ctrl
// Command sequencer: append, clear, and the extract scan/shift passes that
// walk the entry memory one read per cycle through a single compare unit.
// ----------------------------------------------------------------------------
module apq_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [apq_pkg::CMD_W-1:0] cmd_i,
  input  logic [apq_pkg::VAL_W-1:0] value_i,
  input  logic [apq_pkg::PRI_W-1:0] pri_i,
  output apq_pkg::apq_stat_t        stat_o,
  output apq_pkg::apq_res_t         res_o
);
  import apq_pkg::*;

  apq_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [PRI_W-1:0] best_pri_q, best_pri_d;
  logic [VAL_W-1:0] best_val_q, best_val_d;

  logic             we;
  logic [IDX_W-1:0] waddr;
  apq_entry_t       wdata;
  apq_entry_t       rdata;
  logic             issue;
  logic             take;

  apq_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_pri_q <= best_pri_d;
    best_val_q <= best_val_d;
  end

  // single compare: first returned entry seeds, strictly greater replaces
  assign take  = pend_q && ((pend_idx_q == '0) || (rdata.pri > best_pri_q));
  assign issue = (ptr_q < cnt_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    pend_d       = 1'b0;
    pend_idx_d   = ptr_q[IDX_W-1:0];
    best_idx_d   = best_idx_q;
    best_pri_d   = best_pri_q;
    best_val_d   = best_val_q;
    we           = 1'b0;
    waddr        = cnt_q[IDX_W-1:0];
    wdata.value  = value_i;
    wdata.pri    = pri_i;
    res_o.valid  = 1'b0;
    res_o.value  = '0;
    res_o.status = ST_DONE;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            CMD_ADD: begin
              res_o.valid = 1'b1;
              if (cnt_q == CNT_W'(CAPACITY)) begin
                res_o.status = ST_FULL;
              end else begin
                we    = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end
            end
            CMD_EXTRACT: begin
              if (cnt_q == '0) begin
                res_o.valid  = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                state_d = S_SCAN;
                ptr_d   = '0;
              end
            end
            CMD_CLEAR: begin
              res_o.valid = 1'b1;
              cnt_d       = '0;
            end
            default: begin
              res_o.valid = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        pend_d = issue;
        if (issue) begin
          ptr_d = ptr_q + 1'b1;
        end
        if (take) begin
          best_idx_d = pend_idx_q;
          best_pri_d = rdata.pri;
          best_val_d = rdata.value;
        end
        if (!issue && !pend_q) begin
          state_d = S_SHIFT;
          ptr_d   = CNT_W'(best_idx_q) + 1'b1;
        end
      end

      S_SHIFT: begin
        // read entry k while entry k-2 takes the registered read data of entry k-1
        pend_d = issue;
        if (issue) begin
          ptr_d = ptr_q + 1'b1;
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = pend_idx_q - 1'b1;
          wdata = rdata;
        end
        if (!issue && !pend_q) begin
          state_d     = S_IDLE;
          cnt_d       = cnt_q - 1'b1;
          res_o.valid = 1'b1;
          res_o.value = best_val_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.count    = CNT_OUT_W'(cnt_d);
    res_o.is_empty = (cnt_d == '0);
    res_o.is_full  = (cnt_d == CNT_W'(CAPACITY));
  end

  assign stat_o.idle     = (state_q == S_IDLE);
  assign stat_o.cnt_zero = (cnt_q == '0);

endmodule

// ===== rtl/array_priority_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_priority_queue_core
// Priority queue over an unsorted entry memory, stream in, stream out.
// ----------------------------------------------------------------------------
// Each input beat is one command and gives one result beat. Add, clear and
// unknown commands finish in the cycle they are taken, as does an extract on
// an empty queue. Any other extract runs two passes: a scan pass reads
// every entry once through the single read port of the entry memory to
// find the highest priority (earliest wins a tie), then a shift pass moves
// each later entry down one slot, one read and one write a cycle. The input
// is not ready while the passes run. The result sits in an output register,
// so a new command is taken while the last result is leaving.
`include "array_priority_queue_core_assert.svh"

module array_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // value_in[15:0], priority_in[23:16]
  input  logic [1:0]  s_axis_tuser_i,  // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // value_out[15:0], count[21:16],
                                       // is_empty[22], is_full[23]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);
  import apq_pkg::*;

  apq_stat_t stat;
  apq_res_t  res;
  apq_res_t  out_q;
  logic      out_valid_q, out_valid_d;
  logic      out_free;
  logic      accept;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = stat.idle && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  apq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .cmd_i   (s_axis_tuser_i),
    .value_i (s_axis_tdata_i[VAL_W-1:0]),
    .pri_i   (s_axis_tdata_i[VAL_W+PRI_W-1:VAL_W]),
    .stat_o  (stat),
    .res_o   (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.is_full, out_q.is_empty, out_q.count, out_q.value};
  assign m_axis_tuser_o  = out_q.status;

  `APQ_ASSERT_NEXT(a_extract_busy, clk_i, rst_ni, accept && (s_axis_tuser_i == CMD_EXTRACT) && !stat.cnt_zero, !stat.idle, "extract on a non-empty queue did not start a scan")
  `APQ_ASSERT_IMP(a_res_slot_free, clk_i, rst_ni, res.valid, out_free, "result produced while the output register is occupied")
  `APQ_ASSERT_IMP(a_flags_exclusive, clk_i, rst_ni, res.valid, !(res.is_empty && res.is_full), "empty and full flags both set")
  `APQ_ASSERT_IMP(a_empty_status, clk_i, rst_ni, res.valid && (res.status == ST_EMPTY), res.is_empty && (res.value == '0), "empty-extract result is inconsistent")

endmodule

// ===== test/array_priority_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_priority_queue_core_tb
// Self-checking bench for the array priority queue. A short table of
// commands covers empty and tie cases, unknown commands and clears. Random
// fill, drain and mixed episodes follow, with random gaps on both streams,
// long output stalls and full drains. Every result beat is checked against
// the result given in the table or else against a software copy of the queue.
// ----------------------------------------------------------------------------
module array_priority_queue_core_tb;
  import apq_pkg::*;

  localparam int ITEMS_TARGET = 850;
  localparam int LONG_HOLD    = 200;
  localparam int TAIL_CYCLES  = 2 * CAPACITY + 16;

  typedef struct packed {
    logic [VAL_W-1:0]     value;
    logic [STS_W-1:0]     status;
    logic [CNT_OUT_W-1:0] count;
    logic                 is_empty;
    logic                 is_full;
  } pq_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [VAL_W-1:0]     value;
    logic [PRI_W-1:0]     pri;
    logic                 typed;
    pq_result_t           res;
  } cmd_row_t;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;  // undefined opcode, must be ignored
  localparam int N_ROWS = 22;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [23:0]          s_axis_tdata_i;  // value_in[15:0], priority_in[23:16]
  logic [1:0]           s_axis_tuser_i;  // command[1:0]
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [23:0]          m_axis_tdata_o;  // value_out[15:0], count[21:16],
                                         // is_empty[22], is_full[23]
  logic [1:0]           m_axis_tuser_o;  // status[1:0]

  // software copy of the queue
  logic [VAL_W-1:0]     held_value [CAPACITY];
  logic [PRI_W-1:0]     held_pri [CAPACITY];
  int                   held_count;

  pq_result_t           pending_results [$];
  int                   mismatches;
  int                   failures;
  int                   items_sent;
  bit                   burst_mode;
  bit                   hold_out_req;

  cmd_row_t             plan [N_ROWS];

  array_priority_queue_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("** array_priority_queue_core: FAILED **");
    $finish;
  end

  // applies one command to the software queue, returns the result it gives
  function automatic pq_result_t serve_command(input logic [CMD_W-1:0] cmd,
                                               input logic [VAL_W-1:0] val,
                                               input logic [PRI_W-1:0] pri);
    pq_result_t r;
    int         best;
    r.value  = '0;
    r.status = ST_DONE;
    if (cmd == CMD_ADD) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        held_value[held_count] = val;
        held_pri[held_count]   = pri;
        held_count++;
      end
    end else if (cmd == CMD_EXTRACT) begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        best = 0;
        // strict compare keeps the earliest entry on a tie
        for (int i = 1; i < held_count; i++) begin
          if (held_pri[i] > held_pri[best]) best = i;
        end
        r.value = held_value[best];
        for (int i = best; i + 1 < held_count; i++) begin
          held_value[i] = held_value[i+1];
          held_pri[i]   = held_pri[i+1];
        end
        held_count--;
      end
    end else if (cmd == CMD_CLEAR) begin
      held_count = 0;
    end
    r.count    = held_count[CNT_OUT_W-1:0];
    r.is_empty = (held_count == 0);
    r.is_full  = (held_count >= CAPACITY);
    return r;
  endfunction

  // presents one command beat; returns at the edge it is taken
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                       input logic [PRI_W-1:0] pri, input bit typed,
                       input pq_result_t typed_res);
    int         gap;
    pq_result_t pred;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {pri, val};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = serve_command(cmd, val, pri);
    pending_results.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  task automatic drain_pending();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [PRI_W-1:0] pick_pri(input bit narrow);
    if ($urandom_range(0, 15) == 0) return '1;
    if (narrow) return PRI_W'($urandom_range(0, 3));
    return PRI_W'($urandom);
  endfunction

  // mode 0 fills, 1 drains, 2 mixes
  function automatic logic [CMD_W-1:0] pick_cmd(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (roll < 85) return CMD_ADD;
        if (roll < 95) return CMD_EXTRACT;
        if (roll < 96) return CMD_CLEAR;
        return CMD_NOP;
      end
      1: begin
        if (roll < 85) return CMD_EXTRACT;
        if (roll < 95) return CMD_ADD;
        if (roll < 96) return CMD_CLEAR;
        return CMD_NOP;
      end
      default: begin
        if (roll < 45) return CMD_ADD;
        if (roll < 90) return CMD_EXTRACT;
        if (roll < 95) return CMD_CLEAR;
        return CMD_NOP;
      end
    endcase
  endfunction

  // result side
  initial begin
    int         gap;
    pq_result_t want;
    pq_result_t got;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        gap = burst_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.value    = m_axis_tdata_o[15:0];
      got.count    = m_axis_tdata_o[21:16];
      got.is_empty = m_axis_tdata_o[22];
      got.is_full  = m_axis_tdata_o[23];
      got.status   = m_axis_tuser_o;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result beat with none expected: %p", $realtime, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("%0t: mismatch exp val=%h st=%0d cnt=%0d e=%b f=%b, got val=%h st=%0d cnt=%0d e=%b f=%b",
                     $realtime, want.value, want.status, want.count, want.is_empty,
                     want.is_full, got.value, got.status, got.count, got.is_empty,
                     got.is_full);
          mismatches++;
        end
      end
    end
  end

  // command side
  initial begin
    int               mode;
    int               len;
    int               ep;
    bit               narrow;
    logic [CMD_W-1:0] cmd;
    pq_result_t       none;

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    held_count   = 0;
    mismatches   = 0;
    items_sent   = 0;
    burst_mode   = 1'b0;
    hold_out_req = 1'b0;
    none         = '0;

    plan = '{
      '{CMD_EXTRACT, 16'h0000, 8'h00, 1'b1, '{16'h0000, ST_EMPTY, 6'd0, 1'b1, 1'b0}},
      '{CMD_CLEAR,   16'h0000, 8'h00, 1'b1, '{16'h0000, ST_DONE,  6'd0, 1'b1, 1'b0}},
      '{CMD_NOP,     16'h0000, 8'h00, 1'b1, '{16'h0000, ST_DONE,  6'd0, 1'b1, 1'b0}},
      '{CMD_ADD,     16'hFFFF, 8'h00, 1'b1, '{16'h0000, ST_DONE,  6'd1, 1'b0, 1'b0}},
      '{CMD_ADD,     16'h0000, 8'hFF, 1'b1, '{16'h0000, ST_DONE,  6'd2, 1'b0, 1'b0}},
      '{CMD_ADD,     16'hAAAA, 8'hFF, 1'b1, '{16'h0000, ST_DONE,  6'd3, 1'b0, 1'b0}},
      '{CMD_ADD,     16'h5555, 8'h80, 1'b1, '{16'h0000, ST_DONE,  6'd4, 1'b0, 1'b0}},
      // tie on the top priority: earliest arrival first
      '{CMD_EXTRACT, 16'h0000, 8'h00, 1'b1, '{16'h0000, ST_DONE,  6'd3, 1'b0, 1'b0}},
      '{CMD_EXTRACT, 16'h0000, 8'h00, 1'b1, '{16'hAAAA, ST_DONE,  6'd2, 1'b0, 1'b0}},
      '{CMD_EXTRACT, 16'h0000, 8'h00, 1'b1, '{16'h5555, ST_DONE,  6'd1, 1'b0, 1'b0}},
      '{CMD_EXTRACT, 16'h0000, 8'h00, 1'b1, '{16'hFFFF, ST_DONE,  6'd0, 1'b1, 1'b0}},
      '{CMD_EXTRACT, 16'hFFFF, 8'hFF, 1'b1, '{16'h0000, ST_EMPTY, 6'd0, 1'b1, 1'b0}},
      '{CMD_ADD,     16'h1234, 8'h01, 1'b0, none},
      '{CMD_ADD,     16'h4321, 8'h7F, 1'b0, none},
      '{CMD_ADD,     16'h8001, 8'h7F, 1'b0, none},
      '{CMD_ADD,     16'h00FF, 8'h80, 1'b0, none},
      '{CMD_NOP,     16'hFFFF, 8'hFF, 1'b0, none},
      '{CMD_EXTRACT, 16'h0000, 8'h00, 1'b0, none},
      '{CMD_EXTRACT, 16'h0000, 8'h00, 1'b0, none},
      // clear with entries held
      '{CMD_CLEAR,   16'h0000, 8'h00, 1'b1, '{16'h0000, ST_DONE,  6'd0, 1'b1, 1'b0}},
      '{CMD_ADD,     16'h0001, 8'h01, 1'b0, none},
      '{CMD_EXTRACT, 16'h0000, 8'h00, 1'b0, none}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_ROWS; r++)
      offer(plan[r].cmd, plan[r].value, plan[r].pri, plan[r].typed, plan[r].res);

    // first episode fills past capacity under a long output stall,
    // the second drains from full after a complete pause
    ep = 0;
    while (items_sent < ITEMS_TARGET) begin
      mode       = (ep < 2) ? ep : $urandom_range(0, 2);
      len        = (ep == 0) ? 40 : $urandom_range(10, 60);
      narrow     = $urandom_range(0, 1);
      burst_mode = (ep > 1) && ($urandom_range(0, 5) == 0);
      if (ep == 0 || $urandom_range(0, 11) == 0) hold_out_req = 1'b1;
      if (ep == 1 || $urandom_range(0, 9) == 0) drain_pending();
      for (int k = 0; k < len; k++) begin
        cmd = (ep == 0) ? CMD_ADD : pick_cmd(mode);
        offer(cmd, pick_value(), pick_pri(narrow), 1'b0, none);
      end
      ep++;
    end

    drain_pending();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    failures = mismatches + pending_results.size();
    if (failures == 0)
      $display("** array_priority_queue_core: PASSED **");
    else
      $display("** array_priority_queue_core: FAILED **");
    $finish;
  end

endmodule
